FILE: hdl/cbh_pkg.sv
// Shared package for the center-bin size histogram.
// Holds function codes, register indexes and the front-to-back queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbh_pkg;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_ADD  = 2'd1;
	localparam logic [1:0] FUNC_EMIT = 2'd2;
	// unused code, accepted and dropped
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic [0:0] REG_BINS    = 1'b0;
	localparam logic [0:0] REG_DENSITY = 1'b1;

	localparam int CFG_IDX_BITS = 1;

	// command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_EMIT = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [5:0]  idx;
		logic [31:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_DIV,
		ST_EMIT_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/cbh_front.sv
// Front of the histogram: accepts commands, classifies them and queues them.
// Depends on cbh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbh_front #(
	parameter int DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire  [1:0]           func,
	input  wire  [5:0]           bin_index,
	input  wire  [31:0]          center_value,
	input  wire  [31:0]          particle_size,
	output logic                 q_valid,
	output cbh_pkg::entry_t      q_head,
	input  wire                  q_pop
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cbh_pkg::entry_t    mem_q [DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [AW:0]        cnt_q;
	logic               push;
	cbh_pkg::entry_t    e;

	assign busy    = (cnt_q == (AW+1)'(DEPTH));
	assign push    = start && !busy && (func != cbh_pkg::FUNC_NONE);
	assign q_valid = (cnt_q != '0);
	assign q_head  = mem_q[rd_q];

	// classify the command
	always_comb begin
		e.idx   = bin_index;
		e.value = center_value;
		case (func)
			cbh_pkg::FUNC_LOAD: e.cmd = cbh_pkg::CMD_LOAD;
			cbh_pkg::FUNC_ADD: begin
				e.cmd   = cbh_pkg::CMD_ADD;
				e.value = particle_size;
			end
			default: e.cmd = cbh_pkg::CMD_EMIT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/cbh_div.sv
// Restoring divider, one quotient bit per cycle, with saturation to 32 bits.
// No dependencies beyond the standard library.
`timescale 1ns / 1ps
`default_nettype none
module cbh_div #(
	parameter int NB = 56,
	parameter int DB = 24
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           go,
	input  wire  [NB-1:0] num,
	input  wire  [DB-1:0] den,
	output logic          done,
	output logic [31:0]   quot
);
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] q_q;
	logic [DB:0]   r_q;
	logic [DB-1:0] d_q;
	logic [CW-1:0] n_q;
	logic          run_q;
	logic [DB:0]   trial;

	assign trial = {r_q[DB-1:0], q_q[NB-1]};
	assign done  = run_q && (n_q == '0);
	assign quot  = (q_q[NB-1:32] != '0) ? 32'hFFFF_FFFF : q_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			n_q   <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			n_q   <= CW'(NB);
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			n_q <= n_q - 1'b1;
		end
	end

	// shift and subtract step
	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q && n_q != '0) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/cbh_back.sv
// Back of the histogram: bin scan, count update and emit with density division.
// Depends on cbh_pkg and cbh_div.
`timescale 1ns / 1ps
`default_nettype none
module cbh_back #(
	parameter int NUM_BINS   = 32,
	parameter int COUNT_BITS = 24
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [6:0]           bins_in_use,
	input  wire  [31:0]          total_density,
	input  wire                  q_valid,
	input  cbh_pkg::entry_t      q_head,
	output logic                 q_pop,
	output logic                 strobe,
	output logic [31:0]          bin_center,
	output logic [23:0]          bin_count,
	output logic [31:0]          bin_density,
	output logic                 last_bin
);
	localparam int IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int NW = $clog2(NUM_BINS + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic [31:0]           cen_q [NUM_BINS];
	logic [COUNT_BITS-1:0] cnt_q [NUM_BINS];
	logic [COUNT_BITS-1:0] total_q;
	cbh_pkg::state_t       st_q, st_d;
	logic [IW-1:0]         i_q;
	logic [31:0]           p_q;
	logic [NW-1:0]         n_act;
	logic [IW-1:0]         last_i;
	logic                  is_last;
	logic [34:0]           lo2, hi2, p2;
	logic                  hit;
	logic [31:0]           cprev, cnext, ccur;
	logic                  div_go, div_done;
	logic [31:0]           div_q;
	logic [COUNT_BITS+31:0] prod;

	// active bin count, clamped to 2..NUM_BINS
	always_comb begin
		if (bins_in_use < 7'd2) n_act = NW'(2);
		else if (bins_in_use > 7'(NUM_BINS)) n_act = NW'(NUM_BINS);
		else n_act = NW'(bins_in_use);
	end
	assign last_i  = IW'(n_act - 1'b1);
	assign is_last = (i_q == last_i);

	// edges of bin i_q in doubled units, biased by 2^33 to stay unsigned
	assign ccur  = cen_q[i_q];
	assign cprev = (i_q == '0) ? cen_q[1] : cen_q[i_q - 1'b1];
	assign cnext = is_last ? cen_q[i_q - 1'b1] : cen_q[i_q + 1'b1];
	always_comb begin
		if (i_q == '0) lo2 = 35'h2_0000_0000 + 35'(ccur) * 35'd3 - 35'(cprev);
		else lo2 = 35'h2_0000_0000 + 35'(ccur) + 35'(cprev);
		if (is_last) hi2 = 35'h2_0000_0000 + 35'(ccur) * 35'd3 - 35'(cnext);
		else hi2 = 35'h2_0000_0000 + 35'(ccur) + 35'(cnext);
		p2  = 35'h2_0000_0000 + {2'b0, p_q, 1'b0};
		hit = (p2 >= lo2) && (p2 < hi2);
	end

	assign prod = COUNT_BITS'(cnt_q[i_q]) * (COUNT_BITS+32)'(total_density);

	cbh_div #(.NB(COUNT_BITS + 32), .DB(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(prod),
		.den(total_q), .done(div_done), .quot(div_q)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			cbh_pkg::ST_IDLE:
				if (q_valid) begin
					case (q_head.cmd)
						cbh_pkg::CMD_ADD:  st_d = cbh_pkg::ST_SCAN;
						cbh_pkg::CMD_EMIT: st_d = cbh_pkg::ST_EMIT_RD;
						default:           st_d = cbh_pkg::ST_IDLE;
					endcase
				end
			cbh_pkg::ST_SCAN:     if (is_last) st_d = cbh_pkg::ST_IDLE;
			cbh_pkg::ST_EMIT_RD:
				st_d = (total_q == '0) ? cbh_pkg::ST_EMIT_OUT : cbh_pkg::ST_EMIT_DIV;
			cbh_pkg::ST_EMIT_DIV: if (div_done) st_d = cbh_pkg::ST_EMIT_OUT;
			cbh_pkg::ST_EMIT_OUT:
				st_d = is_last ? cbh_pkg::ST_IDLE : cbh_pkg::ST_EMIT_RD;
			default: st_d = cbh_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop  = (st_q == cbh_pkg::ST_IDLE) && q_valid;
		div_go = (st_q == cbh_pkg::ST_EMIT_RD) && (total_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= cbh_pkg::ST_IDLE;
			i_q         <= '0;
			total_q     <= '0;
			strobe      <= 1'b0;
			bin_center  <= '0;
			bin_count   <= '0;
			bin_density <= '0;
			last_bin    <= 1'b0;
			for (int k = 0; k < NUM_BINS; k++) cnt_q[k] <= '0;
		end else begin
			st_q   <= st_d;
			strobe <= 1'b0;
			case (st_q)
				cbh_pkg::ST_IDLE: begin
					i_q <= '0;
					if (q_valid && q_head.cmd == cbh_pkg::CMD_ADD)
						total_q <= (total_q == CMAX) ? CMAX : total_q + 1'b1;
				end
				cbh_pkg::ST_SCAN: begin
					if (hit && cnt_q[i_q] != CMAX) cnt_q[i_q] <= cnt_q[i_q] + 1'b1;
					i_q <= is_last ? '0 : i_q + 1'b1;
				end
				cbh_pkg::ST_EMIT_OUT: begin
					strobe      <= 1'b1;
					bin_center  <= ccur;
					bin_count   <= 24'(cnt_q[i_q]);
					bin_density <= (total_q == '0) ? 32'd0 : div_q;
					last_bin    <= is_last;
					cnt_q[i_q]  <= '0;
					if (is_last) begin
						total_q <= '0;
						i_q     <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// center loads and particle latch
	always_ff @(posedge clk) begin
		if (st_q == cbh_pkg::ST_IDLE && q_valid) begin
			p_q <= q_head.value;
			if (q_head.cmd == cbh_pkg::CMD_LOAD && {1'b0, q_head.idx} < 7'(NUM_BINS))
				cen_q[IW'(q_head.idx)] <= q_head.value;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/center_bin_size_histogram.sv
// Center-bin size histogram. An add item leaves the queue and then steps through each bin
// in use (the bin scan); an emit leaves the queue and then gives one result per bin, each
// through the one-bit-per-cycle density divider, or without the divider when the total is
// zero. Loads write the bin center as they leave the queue. Results appear on strobe
// for one cycle and cannot be stalled. A four-entry queue decouples command acceptance
// (busy) from execution. Write configuration only while no command is in flight.
// Depends on cbh_pkg, cbh_front, cbh_back, cbh_div.
`timescale 1ns / 1ps
`default_nettype none
module center_bin_size_histogram #(
	parameter int NUM_BINS   = 32,
	parameter int COUNT_BITS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  func,
	input  wire  [5:0]  bin_index,
	input  wire  [31:0] center_value,
	input  wire  [31:0] particle_size,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [cbh_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire  [31:0] cfg_data,
	output logic        strobe,
	output logic [31:0] bin_center,
	output logic [23:0] bin_count,
	output logic [31:0] bin_density,
	output logic        last_bin
);
	logic [6:0]       bins_q;
	logic [31:0]      dens_q;
	logic             q_valid, q_pop;
	cbh_pkg::entry_t  q_head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= 7'd32;
			dens_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cbh_pkg::REG_BINS:    bins_q <= cfg_data[6:0];
				cbh_pkg::REG_DENSITY: dens_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cbh_front #(.DEPTH(4)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.bin_index(bin_index), .center_value(center_value),
		.particle_size(particle_size), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
	);

	cbh_back #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .bins_in_use(bins_q), .total_density(dens_q),
		.q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
		.strobe(strobe), .bin_center(bin_center), .bin_count(bin_count),
		.bin_density(bin_density), .last_bin(last_bin)
	);
endmodule
`default_nettype wire
